FILE: design/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed: property violated");
// Expression never true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: design/cdq_pkg.sv
// Types and constants shared by the circular deque modules.
package cdq_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 8;
	localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

	localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
	localparam logic [1:0] MODE_POP_FRONT  = 2'd1;
	localparam logic [1:0] MODE_PUSH_BACK  = 2'd2;
	localparam logic [1:0] MODE_POP_BACK   = 2'd3;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]               mode;
		logic signed [DATA_W-1:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_value;
		logic [1:0]               status;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;     // input transfer this cycle
		logic capture;  // load RAM read data into the result register
		logic cfg_wr;   // capacity write
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pop_read; // current item is a pop that reads storage
	} sts_t;

endpackage

FILE: design/circular_deque_unit.sv
// Circular deque top level: controller plus datapath with ring storage.
// A push or refused op loads the result register on the input transfer; a good pop reads
// the storage RAM (registered read port) and then loads the result register. One item in flight:
// the next input transfer is taken the cycle after the result transfer.
// Reset (arst_n low, async): capacity 128, queue empty, indices at slot 0, controller idle.
// Storage is not cleared; a pop only ever reads slots written earlier.
module circular_deque_unit #(
	parameter int DEPTH = 128
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// item channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  cdq_pkg::in_item_t         in_data,
	// result channel, one result per item
	output logic                      out_valid,
	input  logic                      out_ready,
	output cdq_pkg::out_item_t        out_data,
	// capacity register write; empties the queue
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cdq_pkg::CAP_W-1:0] cfg_data
);

	cdq_pkg::cmd_t cmd;
	cdq_pkg::sts_t sts;

	// state machine: idle -> (read wait on pops) -> result held until transfer
	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// head/tail/count update, ring storage, result register
	cdq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_data (in_data),
		.cfg_data(cfg_data),
		.sts     (sts),
		.out_data(out_data)
	);

endmodule

FILE: design/cdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/cdq_dp.sv
// Deque datapath: ring indices, entry count, capacity, storage and result register.
`include "assert_macros.svh"

module cdq_dp #(
	parameter int DEPTH = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cdq_pkg::cmd_t               cmd,
	input  cdq_pkg::in_item_t           in_data,
	input  logic [cdq_pkg::CAP_W-1:0]   cfg_data,
	output cdq_pkg::sts_t               sts,
	output cdq_pkg::out_item_t          out_data
);

	localparam int IW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);
	localparam int EW = (NW > cdq_pkg::CAP_W) ? NW : cdq_pkg::CAP_W;

	logic [cdq_pkg::CAP_W-1:0] cap_q;
	logic [IW-1:0]             head_q, tail_q;
	logic [NW-1:0]             count_q;
	cdq_pkg::out_item_t        out_q;

	logic [EW-1:0]             cap_w;
	logic [NW-1:0]             ring_n;
	logic                      is_push, is_front, full, empty;
	logic [IW-1:0]             head_up, head_dn, tail_up, tail_dn;
	logic                      we, re;
	logic [IW-1:0]             waddr, raddr;
	logic [cdq_pkg::DATA_W-1:0] rdata;

	function automatic logic [IW-1:0] step_up(input logic [IW-1:0] i, input logic [NW-1:0] n);
		logic [NW:0] nxt;
		nxt = (NW+1)'(i) + (NW+1)'(1);
		return (nxt >= (NW+1)'(n)) ? '0 : IW'(nxt);
	endfunction

	function automatic logic [IW-1:0] step_down(input logic [IW-1:0] i, input logic [NW-1:0] n);
		logic [NW-1:0] nm1;
		nm1 = n - NW'(1);
		return (i == '0 || NW'(i) >= n) ? IW'(nm1) : i - IW'(1);
	endfunction

	// zero capacity acts as one slot, anything above DEPTH as DEPTH
	assign cap_w = EW'(cap_q);
	always_comb begin
		if (cap_w == '0) begin
			ring_n = NW'(1);
		end else if (cap_w > EW'(DEPTH)) begin
			ring_n = NW'(DEPTH);
		end else begin
			ring_n = NW'(cap_w);
		end
	end

	assign is_push  = (in_data.mode == cdq_pkg::MODE_PUSH_FRONT) ||
	                  (in_data.mode == cdq_pkg::MODE_PUSH_BACK);
	assign is_front = (in_data.mode == cdq_pkg::MODE_PUSH_FRONT) ||
	                  (in_data.mode == cdq_pkg::MODE_POP_FRONT);
	assign full     = (count_q >= ring_n);
	assign empty    = (count_q == '0);

	assign head_up = step_up(head_q, ring_n);
	assign head_dn = step_down(head_q, ring_n);
	assign tail_up = step_up(tail_q, ring_n);
	assign tail_dn = step_down(tail_q, ring_n);

	assign sts.pop_read = !is_push && !empty;

	// storage port control
	assign we    = cmd.exec && is_push && !full;
	assign waddr = empty ? '0 : (is_front ? head_dn : tail_up);
	assign re    = cmd.exec && !is_push && !empty;
	assign raddr = is_front ? head_q : tail_q;

	cdq_ram #(
		.WIDTH(cdq_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(in_data.push_value),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= cdq_pkg::CAP_RESET;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.cfg_wr) begin
			cap_q   <= cfg_data;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			if (is_push) begin
				if (!full) begin
					if (empty) begin
						head_q <= '0;
						tail_q <= '0;
					end else if (is_front) begin
						head_q <= head_dn;
					end else begin
						tail_q <= tail_up;
					end
					count_q <= count_q + NW'(1);
				end
			end else if (!empty) begin
				if (count_q == NW'(1)) begin
					head_q <= '0;
					tail_q <= '0;
				end else if (is_front) begin
					head_q <= head_up;
				end else begin
					tail_q <= tail_dn;
				end
				count_q <= count_q - NW'(1);
			end
		end
	end

	// result register; pop data is loaded from the registered RAM read port on capture
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (is_push && !full) begin
				out_q.out_value <= in_data.push_value;
				out_q.status    <= cdq_pkg::STATUS_OK;
			end else if (is_push) begin
				out_q.out_value <= '0;
				out_q.status    <= cdq_pkg::STATUS_FULL;
			end else if (empty) begin
				out_q.out_value <= '0;
				out_q.status    <= cdq_pkg::STATUS_EMPTY;
			end
		end else if (cmd.capture) begin
			out_q.out_value <= rdata;
			out_q.status    <= cdq_pkg::STATUS_OK;
		end
	end

	assign out_data = out_q;

	`ASSERT_NEVER(a_count_in_ring, clk, arst_n, count_q > ring_n)
	`ASSERT_NEVER(a_head_in_ring, clk, arst_n, NW'(head_q) >= ring_n)
	`ASSERT_AT(a_empty_home, clk, arst_n, (count_q == '0) |-> (head_q == '0 && tail_q == '0))

endmodule

FILE: design/cdq_ctrl.sv
// Deque controller: handshake state machine issuing datapath commands.
`include "assert_macros.svh"

module cdq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  cdq_pkg::sts_t sts,
	output cdq_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	logic [1:0] state_q, state_d;
	logic       in_xfer;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_RESP);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;

	assign cmd.exec    = in_xfer;
	assign cmd.capture = (state_q == ST_READ);
	assign cmd.cfg_wr  = cfg_valid;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = sts.pop_read ? ST_READ : ST_RESP;
				end
			end
			ST_READ: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_NEVER(a_one_side, clk, arst_n, in_ready && out_valid)
	`ASSERT_AT(a_pop_waits, clk, arst_n, (in_xfer && sts.pop_read) |=> (state_q == ST_READ))
	`ASSERT_AT(a_direct_result, clk, arst_n, (in_xfer && !sts.pop_read) |=> out_valid)

endmodule

FILE: bench/circular_deque_unit_test.sv
// Self-checking testbench for circular_deque_unit: directed and random deque traffic.
module circular_deque_unit_test;

	localparam int DEPTH = 128;
	// Leaves an order of magnitude of headroom over the worst case, with all stalls and
	// hold-offs stacked, for about 1650 items.
	localparam int LIMIT = 400000;

	// Predicts the result of each accepted transfer and checks results in order.
	class deque_checker;
		logic [cdq_pkg::DATA_W-1:0] ring [DEPTH];
		int unsigned                head;
		int unsigned                tail;
		int unsigned                count;
		logic [cdq_pkg::CAP_W-1:0]  cap;
		cdq_pkg::out_item_t         due_results [$];
		int                         errors;

		function new();
			cap = cdq_pkg::CAP_RESET;
			head = 0;
			tail = 0;
			count = 0;
			errors = 0;
		endfunction

		// A capacity write also empties the queue.
		function void set_capacity(logic [cdq_pkg::CAP_W-1:0] c);
			cap = c;
			head = 0;
			tail = 0;
			count = 0;
		endfunction

		// Zero acts as one slot, anything past the storage depth as the full depth.
		function int unsigned ring_size();
			if (cap == 0)
				return 1;
			if (cap > DEPTH)
				return DEPTH;
			return cap;
		endfunction

		function int unsigned step_up(int unsigned i, int unsigned n);
			return (i + 1 >= n) ? 0 : i + 1;
		endfunction

		function int unsigned step_down(int unsigned i, int unsigned n);
			return (i == 0 || i >= n) ? n - 1 : i - 1;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void predict_op(cdq_pkg::in_item_t op);
			int unsigned        n;
			cdq_pkg::out_item_t r;
			n = ring_size();
			r.out_value = '0;
			r.status = cdq_pkg::STATUS_OK;
			if (op.mode == cdq_pkg::MODE_PUSH_FRONT || op.mode == cdq_pkg::MODE_PUSH_BACK) begin
				if (count >= n) begin
					r.status = cdq_pkg::STATUS_FULL;
				end else begin
					if (count == 0) begin
						// first entry always lands in slot zero
						head = 0;
						tail = 0;
						ring[0] = op.push_value;
					end else if (op.mode == cdq_pkg::MODE_PUSH_FRONT) begin
						head = step_down(head, n);
						ring[head] = op.push_value;
					end else begin
						tail = step_up(tail, n);
						ring[tail] = op.push_value;
					end
					count++;
					r.out_value = op.push_value;
				end
			end else if (count == 0) begin
				r.status = cdq_pkg::STATUS_EMPTY;
			end else begin
				if (op.mode == cdq_pkg::MODE_POP_FRONT) begin
					r.out_value = ring[head];
					head = step_up(head, n);
				end else begin
					r.out_value = ring[tail];
					tail = step_down(tail, n);
				end
				count--;
				if (count == 0) begin
					head = 0;
					tail = 0;
				end
			end
			due_results.push_back(r);
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 50)
				$display("mismatch: %s", what);
		endtask

		task check_result(cdq_pkg::out_item_t got);
			cdq_pkg::out_item_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %0d status %0d",
					got.out_value, got.status));
				return;
			end
			want = due_results.pop_front();
			if (got.out_value !== want.out_value)
				report_mismatch($sformatf("out_value %0d, expected %0d",
					got.out_value, want.out_value));
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d",
					got.status, want.status));
		endtask
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	cdq_pkg::in_item_t         in_data = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	cdq_pkg::out_item_t        out_data;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [cdq_pkg::CAP_W-1:0] cfg_data = '0;

	deque_checker chk;
	int           send_idle_pct = 0;  // chance per cycle that the sender holds back
	int           stall_pct = 0;      // chance per cycle that the receiver stalls
	int           hold_left = 0;      // long receiver hold-off, counted down by the receiver
	int           cycle_count = 0;

	circular_deque_unit #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Monitor: both channels sampled at the rising edge, where the handshake counts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				chk.predict_op(in_data);
			if (out_valid && out_ready)
				chk.check_result(out_data);
		end
	end

	// Receiver: out_ready moves on falling edges. A requested hold-off is worked off
	// here, one cycle at a time, regardless of what the sender is doing.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one transfer, with random idle cycles ahead of it. Returns at the rising
	// edge where it was accepted; valid stays high until the next falling edge decides.
	task automatic send_item(input cdq_pkg::in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_op(input logic [1:0] mode, input logic [cdq_pkg::DATA_W-1:0] value);
		cdq_pkg::in_item_t it;
		it.mode = mode;
		it.push_value = value;
		send_item(it);
	endtask

	// Drop valid and wait until every predicted result has come back.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (chk.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Capacity is only written with the block idle.
	task automatic write_capacity(input logic [cdq_pkg::CAP_W-1:0] c);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		chk.set_capacity(c);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic cdq_pkg::in_item_t random_op(input int push_pct);
		cdq_pkg::in_item_t it;
		if ($urandom_range(99) < push_pct)
			it.mode = $urandom_range(1) ? cdq_pkg::MODE_PUSH_BACK : cdq_pkg::MODE_PUSH_FRONT;
		else
			it.mode = $urandom_range(1) ? cdq_pkg::MODE_POP_BACK : cdq_pkg::MODE_POP_FRONT;
		case ($urandom_range(9))
			0: it.push_value = 32'h7fff_ffff;
			1: it.push_value = 32'h8000_0000;
			default: it.push_value = $urandom;
		endcase
		return it;
	endfunction

	// Alternate push-heavy and pop-heavy bursts so the queue swings between empty
	// and full, wrapping both indices around the ring on the way.
	task automatic run_items(input int total, input int pause_at);
		int push_pct;
		int burst;
		push_pct = 15;
		burst = 0;
		for (int k = 0; k < total; k++) begin
			if (burst == 0) begin
				push_pct = (push_pct > 50) ? 15 : 85;
				burst = $urandom_range(8, 160);
			end
			burst--;
			if (k == pause_at)
				wait_drained();
			send_item(random_op(push_pct));
		end
	endtask

	logic [cdq_pkg::CAP_W-1:0] phase_caps [8] =
		'{8'd128, 8'd2, 8'd255, 8'd5, 8'd0, 8'd17, 8'd1, 8'd64};

	initial begin
		chk = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty pops, first push into slot zero, extreme values, last pop.
		send_op(cdq_pkg::MODE_POP_FRONT, 32'h0);
		send_op(cdq_pkg::MODE_POP_BACK, 32'hffff_ffff);
		send_op(cdq_pkg::MODE_PUSH_FRONT, 32'h7fff_ffff);
		send_op(cdq_pkg::MODE_PUSH_BACK, 32'h8000_0000);
		send_op(cdq_pkg::MODE_PUSH_FRONT, 32'hffff_ffff);
		send_op(cdq_pkg::MODE_PUSH_BACK, 32'h0);
		send_op(cdq_pkg::MODE_POP_BACK, 32'h0);
		send_op(cdq_pkg::MODE_POP_FRONT, 32'h0);
		send_op(cdq_pkg::MODE_POP_FRONT, 32'h0);
		send_op(cdq_pkg::MODE_POP_BACK, 32'h0);
		send_op(cdq_pkg::MODE_POP_FRONT, 32'h0);

		// One slot: second push refused, then refill from the front.
		write_capacity(8'd1);
		send_op(cdq_pkg::MODE_PUSH_BACK, 32'h1234_5678);
		send_op(cdq_pkg::MODE_PUSH_FRONT, 32'h5555_5555);
		send_op(cdq_pkg::MODE_POP_BACK, 32'h0);
		send_op(cdq_pkg::MODE_PUSH_FRONT, 32'haaaa_aaaa);
		send_op(cdq_pkg::MODE_POP_FRONT, 32'h0);

		// Capacity zero behaves as one slot; a later write throws the entry away.
		write_capacity(8'd0);
		send_op(cdq_pkg::MODE_PUSH_FRONT, 32'h0000_0001);
		send_op(cdq_pkg::MODE_PUSH_BACK, 32'h0000_0002);
		send_op(cdq_pkg::MODE_POP_FRONT, 32'h0);
		send_op(cdq_pkg::MODE_PUSH_BACK, 32'hdead_beef);
		write_capacity(8'd3);
		send_op(cdq_pkg::MODE_POP_FRONT, 32'h0);

		// Random phases, rotating through the idling patterns.
		for (int ph = 0; ph < 8; ph++) begin
			write_capacity(phase_caps[ph]);
			@(posedge clk);
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 65; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 65; end
				default: begin send_idle_pct = 8; stall_pct = 8; end
			endcase
			// Receiver goes quiet for a long stretch while items keep coming.
			if (ph == 4) begin
				send_idle_pct = 0;
				hold_left = 300;
			end
			run_items(200, (ph == 5) ? 100 : -1);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (chk.errors == 0 && chk.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
